>>> hdl/cao_pkg.sv
// Shared types and constants for the cursor alpha overlay.
package cao_pkg;

    // Field widths fixed by the stream format
    localparam int COORD_W    = 12;
    localparam int IDX_W      = 12;
    localparam int ARGB_W     = 32;
    localparam int CH_W       = 8;
    localparam int POS_W      = 14;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Full-scale channel value
    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

    // Cursor placement and size
    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic [SIZE_W-1:0]       width;
        logic [SIZE_W-1:0]       height;
        logic                    enable;
    } cfg_t;

    // One BGRA frame pixel
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] alpha;
    } pix_t;

    // Per-stage control that travels with each item
    typedef struct packed {
        logic valid;   // stage holds an item
        logic blend;   // item is a frame pixel, else a cursor load
        logic in_rect; // pixel lies in the enabled cursor rectangle
        logic wr;      // load with an in-range store index
    } ctl_t;

endpackage

>>> hdl/cao_locate.sv
// Coordinate stages: cursor-relative position, rectangle test and store address.
module cao_locate #(
    parameter int CURSOR_MAX_SIDE = 64,
    parameter int FRAME_MAX_SIDE  = 4096
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  cao_pkg::cfg_t                                 cfg,
    input  logic                                          in_valid,
    input  logic                                          in_command,
    input  logic [cao_pkg::COORD_W-1:0]                   in_pixel_x,
    input  logic [cao_pkg::COORD_W-1:0]                   in_pixel_y,
    input  logic [cao_pkg::IDX_W-1:0]                     in_cursor_index,
    input  logic [cao_pkg::ARGB_W-1:0]                    in_cursor_argb,
    input  cao_pkg::pix_t                                 in_pix,
    output cao_pkg::ctl_t                                 out_ctl,
    output logic [$clog2(CURSOR_MAX_SIDE*CURSOR_MAX_SIDE)-1:0] out_addr,
    output logic [cao_pkg::ARGB_W-1:0]                    out_argb,
    output cao_pkg::pix_t                                 out_pix
);

    localparam int DEPTH  = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(CURSOR_MAX_SIDE);
    localparam int SIDE_W = $clog2(CURSOR_MAX_SIDE + 1);
    localparam int OFF_W  = cao_pkg::POS_W + 1;
    localparam int WIDE_W = cao_pkg::IDX_W + ADDR_W;
    localparam int PROD_W = CW + SIDE_W;

    // Clamp the cursor size to the store side
    logic [SIDE_W-1:0] w_eff;
    logic [SIDE_W-1:0] h_eff;

    always_comb begin
        if (10'(cfg.width) > 10'(CURSOR_MAX_SIDE)) begin
            w_eff = SIDE_W'(CURSOR_MAX_SIDE);
        end else begin
            w_eff = SIDE_W'(cfg.width);
        end
        if (10'(cfg.height) > 10'(CURSOR_MAX_SIDE)) begin
            h_eff = SIDE_W'(CURSOR_MAX_SIDE);
        end else begin
            h_eff = SIDE_W'(cfg.height);
        end
    end

    // Stage 1: offsets into the cursor image and rectangle test
    logic [OFF_W-1:0]        px_ext;
    logic [OFF_W-1:0]        py_ext;
    logic signed [OFF_W-1:0] cx;
    logic signed [OFF_W-1:0] cy;
    logic                    in_x;
    logic                    in_y;
    logic                    frame_ok;
    logic [WIDE_W-1:0]       idx_wide;
    logic                    idx_ok;

    assign px_ext   = {{(OFF_W-cao_pkg::COORD_W){1'b0}}, in_pixel_x};
    assign py_ext   = {{(OFF_W-cao_pkg::COORD_W){1'b0}}, in_pixel_y};
    assign cx       = $signed(px_ext) - $signed({cfg.left[cao_pkg::POS_W-1], cfg.left});
    assign cy       = $signed(py_ext) - $signed({cfg.top[cao_pkg::POS_W-1], cfg.top});
    assign in_x     = !cx[OFF_W-1] && (cx[OFF_W-2:0] < (OFF_W-1)'(w_eff));
    assign in_y     = !cy[OFF_W-1] && (cy[OFF_W-2:0] < (OFF_W-1)'(h_eff));
    assign frame_ok = (px_ext < OFF_W'(FRAME_MAX_SIDE)) && (py_ext < OFF_W'(FRAME_MAX_SIDE));
    assign idx_wide = WIDE_W'(in_cursor_index);
    assign idx_ok   = idx_wide < WIDE_W'(DEPTH);

    cao_pkg::ctl_t     ctl1_reg;
    cao_pkg::ctl_t     ctl1_next;
    logic [CW-1:0]     cx1_reg;
    logic [CW-1:0]     cy1_reg;
    logic [ADDR_W-1:0] idx1_reg;
    logic [cao_pkg::ARGB_W-1:0] argb1_reg;
    cao_pkg::pix_t     pix1_reg;

    always_comb begin
        ctl1_next.valid   = in_valid;
        ctl1_next.blend   = in_command;
        ctl1_next.in_rect = cfg.enable && frame_ok && in_x && in_y;
        ctl1_next.wr      = !in_command && idx_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
        end else if (adv) begin
            ctl1_reg <= ctl1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx1_reg   <= cx[CW-1:0];
            cy1_reg   <= cy[CW-1:0];
            idx1_reg  <= idx_wide[ADDR_W-1:0];
            argb1_reg <= in_cursor_argb;
            pix1_reg  <= in_pix;
        end
    end

    // Stage 2: row-major store address, or the load index
    logic [PROD_W-1:0] map_prod;
    logic [PROD_W:0]   map_sum;
    logic [ADDR_W-1:0] addr2_next;
    cao_pkg::ctl_t     ctl2_next;
    cao_pkg::ctl_t     ctl2_reg;
    logic [ADDR_W-1:0] addr2_reg;
    logic [cao_pkg::ARGB_W-1:0] argb2_reg;
    cao_pkg::pix_t     pix2_reg;

    assign map_prod   = PROD_W'(cy1_reg) * PROD_W'(w_eff);
    assign map_sum    = (PROD_W+1)'(map_prod) + (PROD_W+1)'(cx1_reg);
    assign addr2_next = ctl1_reg.blend ? map_sum[ADDR_W-1:0] : idx1_reg;

    always_comb begin
        ctl2_next    = ctl1_reg;
        ctl2_next.wr = ctl1_reg.valid && ctl1_reg.wr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg <= '0;
        end else if (adv) begin
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            addr2_reg <= addr2_next;
            argb2_reg <= argb1_reg;
            pix2_reg  <= pix1_reg;
        end
    end

    assign out_ctl  = ctl2_reg;
    assign out_addr = addr2_reg;
    assign out_argb = argb2_reg;
    assign out_pix  = pix2_reg;

endmodule

>>> hdl/cao_store.sv
// Cursor image store: one write or one registered read per cycle while the pipe advances.
module cao_store #(
    parameter int CURSOR_MAX_SIDE = 64
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          adv,
    input  cao_pkg::ctl_t                                 in_ctl,
    input  logic [$clog2(CURSOR_MAX_SIDE*CURSOR_MAX_SIDE)-1:0] in_addr,
    input  logic [cao_pkg::ARGB_W-1:0]                    in_argb,
    input  cao_pkg::pix_t                                 in_pix,
    output cao_pkg::ctl_t                                 out_ctl,
    output logic [cao_pkg::ARGB_W-1:0]                    out_rdata,
    output cao_pkg::pix_t                                 out_pix
);

    localparam int DEPTH = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;

    logic [cao_pkg::ARGB_W-1:0] mem [DEPTH];
    logic [cao_pkg::ARGB_W-1:0] rdata_reg;
    cao_pkg::ctl_t              ctl3_reg;
    cao_pkg::ctl_t              ctl3_next;
    cao_pkg::pix_t              pix3_reg;

    // Loads end here; only frame pixels go on
    always_comb begin
        ctl3_next       = in_ctl;
        ctl3_next.valid = in_ctl.valid && in_ctl.blend;
        ctl3_next.wr    = 1'b0;
    end

    // Store port: items reach it in order, so reads see all earlier loads
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (in_ctl.wr) begin
                mem[in_addr] <= in_argb;
            end
            rdata_reg <= mem[in_addr];
            pix3_reg  <= in_pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg <= '0;
        end else if (adv) begin
            ctl3_reg <= ctl3_next;
        end
    end

    assign out_ctl   = ctl3_reg;
    assign out_rdata = rdata_reg;
    assign out_pix   = pix3_reg;

endmodule

>>> hdl/cao_blend.sv
// Blend stages: alpha-weighted products, then exact divide by 255.
module cao_blend (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  cao_pkg::ctl_t              in_ctl,
    input  logic [cao_pkg::ARGB_W-1:0] in_rdata,
    input  cao_pkg::pix_t              in_pix,
    output logic                       out_valid,
    output cao_pkg::pix_t              out_pix,
    output logic                       out_hit
);

    localparam int SUM_W = 2 * cao_pkg::CH_W;

    // floor(n / 255) for n below 65280
    function automatic logic [cao_pkg::CH_W-1:0] div255(input logic [SUM_W-1:0] n);
        logic [SUM_W:0] t;
        t = (SUM_W+1)'(n) + (SUM_W+1)'(n >> cao_pkg::CH_W) + (SUM_W+1)'(1);
        return t[SUM_W-1:cao_pkg::CH_W];
    endfunction

    // Stage 4: dst*(255-a) + src*a per channel; outside the cursor a is zero
    logic [cao_pkg::CH_W-1:0] a;
    logic [cao_pkg::CH_W-1:0] ia;
    logic [SUM_W-1:0]         sum_b_next;
    logic [SUM_W-1:0]         sum_g_next;
    logic [SUM_W-1:0]         sum_r_next;

    assign a  = in_ctl.in_rect ? in_rdata[31:24] : '0;
    assign ia = cao_pkg::CH_MAX - a;
    assign sum_b_next = SUM_W'(in_pix.blue) * SUM_W'(ia)
                      + SUM_W'(in_rdata[7:0]) * SUM_W'(a);
    assign sum_g_next = SUM_W'(in_pix.green) * SUM_W'(ia)
                      + SUM_W'(in_rdata[15:8]) * SUM_W'(a);
    assign sum_r_next = SUM_W'(in_pix.red) * SUM_W'(ia)
                      + SUM_W'(in_rdata[23:16]) * SUM_W'(a);

    logic                     v4_reg;
    logic [SUM_W-1:0]         sum_b_reg;
    logic [SUM_W-1:0]         sum_g_reg;
    logic [SUM_W-1:0]         sum_r_reg;
    logic [cao_pkg::CH_W-1:0] alpha4_reg;
    logic                     hit4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_b_reg  <= sum_b_next;
            sum_g_reg  <= sum_g_next;
            sum_r_reg  <= sum_r_next;
            alpha4_reg <= in_pix.alpha;
            hit4_reg   <= (a != '0);
        end
    end

    // Stage 5: divide and hold as the output register
    logic          v5_reg;
    cao_pkg::pix_t pix5_reg;
    logic          hit5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix5_reg.blue  <= div255(sum_b_reg);
            pix5_reg.green <= div255(sum_g_reg);
            pix5_reg.red   <= div255(sum_r_reg);
            pix5_reg.alpha <= alpha4_reg;
            hit5_reg       <= hit4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_pix   = pix5_reg;
    assign out_hit   = hit5_reg;

endmodule

>>> hdl/cursor_alpha_overlay_top.sv
// Top level of the cursor alpha overlay: config registers, pipeline and handshake.
//
//  channel  direction  handshake            content
//  s_       in         s_valid / s_ready    cursor load or frame pixel with x, y
//  m_       out        m_valid / m_ready    blended BGRA pixel and cursor_hit
//  cfg_     in         cfg_wr_en            cursor position, size, enable
//
// One item per cycle while the output is not stalled; five register stages from transfer
// to result (offset, address, store read, products, divide and output).
// Loads leave the pipe after the store stage and give no result.
// aresetn is synchronous; it empties the pipe and sets the register defaults.
// A stalled output freezes the whole pipe and holds s_ready low.
module cursor_alpha_overlay_top #(
    parameter int CURSOR_MAX_SIDE = 64,
    parameter int FRAME_MAX_SIDE  = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cao_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cao_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_command,
    input  logic [cao_pkg::COORD_W-1:0]      s_pixel_x,
    input  logic [cao_pkg::COORD_W-1:0]      s_pixel_y,
    input  logic [cao_pkg::IDX_W-1:0]        s_cursor_index,
    input  logic [cao_pkg::ARGB_W-1:0]       s_cursor_argb,
    input  logic [cao_pkg::CH_W-1:0]         s_dst_blue,
    input  logic [cao_pkg::CH_W-1:0]         s_dst_green,
    input  logic [cao_pkg::CH_W-1:0]         s_dst_red,
    input  logic [cao_pkg::CH_W-1:0]         s_dst_alpha,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [cao_pkg::CH_W-1:0]         m_out_blue,
    output logic [cao_pkg::CH_W-1:0]         m_out_green,
    output logic [cao_pkg::CH_W-1:0]         m_out_red,
    output logic [cao_pkg::CH_W-1:0]         m_out_alpha,
    output logic                             m_cursor_hit
);

    localparam int ADDR_W = $clog2(CURSOR_MAX_SIDE * CURSOR_MAX_SIDE);

    // Configuration registers
    cao_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left   <= '0;
            cfg_reg.top    <= '0;
            cfg_reg.width  <= cao_pkg::SIZE_W'(64);
            cfg_reg.height <= cao_pkg::SIZE_W'(64);
            cfg_reg.enable <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cao_pkg::REG_LEFT:   cfg_reg.left   <= $signed(cfg_wr_data);
                cao_pkg::REG_TOP:    cfg_reg.top    <= $signed(cfg_wr_data);
                cao_pkg::REG_WIDTH:  cfg_reg.width  <= cfg_wr_data[cao_pkg::SIZE_W-1:0];
                cao_pkg::REG_HEIGHT: cfg_reg.height <= cfg_wr_data[cao_pkg::SIZE_W-1:0];
                cao_pkg::REG_ENABLE: cfg_reg.enable <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Pipe moves whenever the output register is free or being emptied
    logic pipe_adv;

    assign pipe_adv = !m_valid || m_ready;
    assign s_ready  = pipe_adv;

    cao_pkg::pix_t in_pix;

    assign in_pix.blue  = s_dst_blue;
    assign in_pix.green = s_dst_green;
    assign in_pix.red   = s_dst_red;
    assign in_pix.alpha = s_dst_alpha;

    cao_pkg::ctl_t              st2_ctl;
    logic [ADDR_W-1:0]          st2_addr;
    logic [cao_pkg::ARGB_W-1:0] st2_argb;
    cao_pkg::pix_t              st2_pix;

    cao_locate #(
        .CURSOR_MAX_SIDE (CURSOR_MAX_SIDE),
        .FRAME_MAX_SIDE  (FRAME_MAX_SIDE)
    ) u_locate (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (pipe_adv),
        .cfg             (cfg_reg),
        .in_valid        (s_valid),
        .in_command      (s_command),
        .in_pixel_x      (s_pixel_x),
        .in_pixel_y      (s_pixel_y),
        .in_cursor_index (s_cursor_index),
        .in_cursor_argb  (s_cursor_argb),
        .in_pix          (in_pix),
        .out_ctl         (st2_ctl),
        .out_addr        (st2_addr),
        .out_argb        (st2_argb),
        .out_pix         (st2_pix)
    );

    cao_pkg::ctl_t              st3_ctl;
    logic [cao_pkg::ARGB_W-1:0] st3_rdata;
    cao_pkg::pix_t              st3_pix;

    cao_store #(
        .CURSOR_MAX_SIDE (CURSOR_MAX_SIDE)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_ctl    (st2_ctl),
        .in_addr   (st2_addr),
        .in_argb   (st2_argb),
        .in_pix    (st2_pix),
        .out_ctl   (st3_ctl),
        .out_rdata (st3_rdata),
        .out_pix   (st3_pix)
    );

    cao_pkg::pix_t out_pix;

    cao_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (pipe_adv),
        .in_ctl    (st3_ctl),
        .in_rdata  (st3_rdata),
        .in_pix    (st3_pix),
        .out_valid (m_valid),
        .out_pix   (out_pix),
        .out_hit   (m_cursor_hit)
    );

    assign m_out_blue  = out_pix.blue;
    assign m_out_green = out_pix.green;
    assign m_out_red   = out_pix.red;
    assign m_out_alpha = out_pix.alpha;

`ifndef SYNTHESIS
    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A held result blocks new transfers
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // A stall freezes the address-stage and store-stage control
    a_stall_freezes_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_adv |=> $stable(st2_ctl) && $stable(st3_ctl))
        else $error("pipeline moved during stall");

    // Only frame pixels reach the blend stages
    a_no_load_past_store: assert property (@(posedge aclk) disable iff (!aresetn)
        st3_ctl.valid |-> st3_ctl.blend)
        else $error("cursor load passed the store stage");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the cursor alpha overlay: cursor loads, pixel blends, checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_BLEND   = 1'b1;
    localparam int   CLK_PERIOD  = 10;
    localparam int   CURSOR_SIDE = 64;
    localparam int   STORE_DEPTH = CURSOR_SIDE * CURSOR_SIDE;
    localparam int   FRAME_SIDE  = 4096;
    localparam int   PIPE_DRAIN  = 8;
    localparam int   HOLD_CYCLES = 300;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   MAX_REPORTS = 10;

    // One stream item: either a cursor load or a frame pixel
    typedef struct {
        logic                        command;
        logic [cao_pkg::COORD_W-1:0] x;
        logic [cao_pkg::COORD_W-1:0] y;
        logic [cao_pkg::IDX_W-1:0]   idx;
        logic [cao_pkg::ARGB_W-1:0]  argb;
        cao_pkg::pix_t               dst;
    } stream_item_t;

    // One blended output pixel
    typedef struct {
        cao_pkg::pix_t pix;
        logic          hit;
    } blended_px_t;

    logic                           aclk           = 1'b0;
    logic                           aresetn        = 1'b0;
    logic                           cfg_wr_en      = 1'b0;
    logic [cao_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [cao_pkg::CFG_DATA_W-1:0] cfg_wr_data    = '0;
    logic                           s_valid        = 1'b0;
    logic                           s_ready;
    logic                           s_command      = 1'b0;
    logic [cao_pkg::COORD_W-1:0]    s_pixel_x      = '0;
    logic [cao_pkg::COORD_W-1:0]    s_pixel_y      = '0;
    logic [cao_pkg::IDX_W-1:0]      s_cursor_index = '0;
    logic [cao_pkg::ARGB_W-1:0]     s_cursor_argb  = '0;
    logic [cao_pkg::CH_W-1:0]       s_dst_blue     = '0;
    logic [cao_pkg::CH_W-1:0]       s_dst_green    = '0;
    logic [cao_pkg::CH_W-1:0]       s_dst_red      = '0;
    logic [cao_pkg::CH_W-1:0]       s_dst_alpha    = '0;
    logic                           m_valid;
    logic                           m_ready        = 1'b0;
    logic [cao_pkg::CH_W-1:0]       m_out_blue;
    logic [cao_pkg::CH_W-1:0]       m_out_green;
    logic [cao_pkg::CH_W-1:0]       m_out_red;
    logic [cao_pkg::CH_W-1:0]       m_out_alpha;
    logic                           m_cursor_hit;

    // Shadow of the cursor registers and the cursor image
    int   cur_left   = 0;
    int   cur_top    = 0;
    int   cur_width  = 64;
    int   cur_height = 64;
    bit   cur_enable = 1'b1;
    logic [cao_pkg::ARGB_W-1:0] cursor_img  [STORE_DEPTH];
    bit                         img_written [STORE_DEPTH];

    stream_item_t pending_items [$];
    blended_px_t  expected_px   [$];
    stream_item_t on_bus;

    int mismatches     = 0;
    int cycle_count    = 0;
    int stall_requests = 0;
    int stalls_served  = 0;
    int hold_left      = 0;
    bit steady_flow    = 1'b0;

    cursor_alpha_overlay_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pixel_x      (s_pixel_x),
        .s_pixel_y      (s_pixel_y),
        .s_cursor_index (s_cursor_index),
        .s_cursor_argb  (s_cursor_argb),
        .s_dst_blue     (s_dst_blue),
        .s_dst_green    (s_dst_green),
        .s_dst_red      (s_dst_red),
        .s_dst_alpha    (s_dst_alpha),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_blue     (m_out_blue),
        .m_out_green    (m_out_green),
        .m_out_red      (m_out_red),
        .m_out_alpha    (m_out_alpha),
        .m_cursor_hit   (m_cursor_hit)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int side_clamp(input int v);
        return (v > CURSOR_SIDE) ? CURSOR_SIDE : v;
    endfunction

    // True when the enabled cursor covers (x, y); sidx gets the image entry it reads
    function automatic bit cursor_covers(input logic [cao_pkg::COORD_W-1:0] x,
                                         input logic [cao_pkg::COORD_W-1:0] y,
                                         output int sidx);
        int cx, cy, wc, hc;
        wc   = side_clamp(cur_width);
        hc   = side_clamp(cur_height);
        cx   = int'(x) - cur_left;
        cy   = int'(y) - cur_top;
        sidx = cy * wc + cx;
        return cur_enable && cx >= 0 && cx < wc && cy >= 0 && cy < hc;
    endfunction

    // Exact integer alpha mix, floor((d*(255-a) + s*a) / 255)
    function automatic logic [cao_pkg::CH_W-1:0] channel_mix(
            input logic [cao_pkg::CH_W-1:0] d,
            input logic [cao_pkg::CH_W-1:0] s,
            input int a);
        int full, v;
        full = int'(cao_pkg::CH_MAX);
        v    = (int'(d) * (full - a) + int'(s) * a) / full;
        return v[cao_pkg::CH_W-1:0];
    endfunction

    // Expected output pixel for a blend item under the current cursor setup
    function automatic blended_px_t blend_expect(input stream_item_t it);
        blended_px_t                r;
        int                         sidx, a;
        logic [cao_pkg::ARGB_W-1:0] c;
        r.pix = it.dst;
        r.hit = 1'b0;
        if (cursor_covers(it.x, it.y, sidx)) begin
            c = cursor_img[sidx];
            a = int'(c[31:24]);
            if (a == int'(cao_pkg::CH_MAX)) begin
                r.pix.blue  = c[7:0];
                r.pix.green = c[15:8];
                r.pix.red   = c[23:16];
                r.hit       = 1'b1;
            end else if (a != 0) begin
                r.pix.blue  = channel_mix(it.dst.blue,  c[7:0],   a);
                r.pix.green = channel_mix(it.dst.green, c[15:8],  a);
                r.pix.red   = channel_mix(it.dst.red,   c[23:16], a);
                r.hit       = 1'b1;
            end
        end
        return r;
    endfunction

    // Cursor pixel with alpha skewed toward transparent and opaque
    function automatic logic [cao_pkg::ARGB_W-1:0] random_argb();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: r[31:24] = 8'h00;
            1: r[31:24] = cao_pkg::CH_MAX;
            default: ;
        endcase
        return r;
    endfunction

    task automatic push_load(input int idx, input logic [cao_pkg::ARGB_W-1:0] argb);
        stream_item_t it;
        logic [31:0]  r;
        r          = $urandom;
        it.command = CMD_LOAD;
        it.x       = r[11:0];
        it.y       = r[23:12];
        it.idx     = idx[cao_pkg::IDX_W-1:0];
        it.argb    = argb;
        it.dst     = $urandom;
        pending_items.push_back(it);
        img_written[idx] = 1'b1;
    endtask

    // Blend item; an image entry it would read is loaded first if still unwritten
    task automatic push_blend(input int x, input int y, input cao_pkg::pix_t dst);
        stream_item_t it;
        logic [31:0]  r;
        int           sidx;
        it.command = CMD_BLEND;
        it.x       = x[cao_pkg::COORD_W-1:0];
        it.y       = y[cao_pkg::COORD_W-1:0];
        r          = $urandom;
        it.idx     = r[cao_pkg::IDX_W-1:0];
        it.argb    = $urandom;
        it.dst     = dst;
        if (cursor_covers(it.x, it.y, sidx) && !img_written[sidx])
            push_load(sidx, random_argb());
        pending_items.push_back(it);
    endtask

    // Mix of image loads and frame pixels, most of them over the cursor
    task automatic gen_traffic(input int n);
        int wc, hc, xlo, xhi, ylo, yhi, x, y, k;
        wc  = side_clamp(cur_width);
        hc  = side_clamp(cur_height);
        xlo = (cur_left > 0) ? cur_left : 0;
        ylo = (cur_top > 0) ? cur_top : 0;
        xhi = (cur_left + wc - 1 < FRAME_SIDE - 1) ? cur_left + wc - 1 : FRAME_SIDE - 1;
        yhi = (cur_top + hc - 1 < FRAME_SIDE - 1) ? cur_top + hc - 1 : FRAME_SIDE - 1;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 25) begin
                if (wc * hc > 0 && $urandom_range(9) != 0)
                    push_load(int'($urandom_range(wc * hc - 1)), random_argb());
                else
                    push_load(int'($urandom_range(STORE_DEPTH - 1)), random_argb());
            end else begin
                if (xlo <= xhi && ylo <= yhi && $urandom_range(99) < 70) begin
                    x = int'($urandom_range(xhi, xlo));
                    y = int'($urandom_range(yhi, ylo));
                end else if ($urandom_range(1) == 1) begin
                    // around the rectangle border
                    x = cur_left - 1 + int'($urandom_range(wc + 1));
                    y = cur_top - 1 + int'($urandom_range(hc + 1));
                    if (x < 0 || x >= FRAME_SIDE) x = int'($urandom_range(FRAME_SIDE - 1));
                    if (y < 0 || y >= FRAME_SIDE) y = int'($urandom_range(FRAME_SIDE - 1));
                end else begin
                    x = int'($urandom_range(FRAME_SIDE - 1));
                    y = int'($urandom_range(FRAME_SIDE - 1));
                end
                push_blend(x, y, $urandom);
            end
        end
    endtask

    // Block until nothing is queued, on the bus or outstanding, then let loads retire
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_px.size() != 0)
            @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [cao_pkg::CFG_IDX_W-1:0] index,
                           input logic [cao_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Program all cursor registers once the pipe is empty
    task automatic set_cursor(input int left, input int top, input int width,
                              input int height, input bit en);
        logic [31:0] r;
        wait_drained();
        r          = $urandom;
        cur_left   = left;
        cur_top    = top;
        cur_width  = width;
        cur_height = height;
        cur_enable = en;
        cfg_put(cao_pkg::REG_LEFT,   left[cao_pkg::CFG_DATA_W-1:0]);
        cfg_put(cao_pkg::REG_TOP,    top[cao_pkg::CFG_DATA_W-1:0]);
        cfg_put(cao_pkg::REG_WIDTH,  {r[6:0], width[cao_pkg::SIZE_W-1:0]});
        cfg_put(cao_pkg::REG_HEIGHT, {r[13:7], height[cao_pkg::SIZE_W-1:0]});
        cfg_put(cao_pkg::REG_ENABLE, {r[26:14], en});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_cursor();
        int w, h;
        case ($urandom_range(9))
            0: w = 0;
            1: w = int'($urandom_range(127, 65));
            default: w = int'($urandom_range(64, 1));
        endcase
        case ($urandom_range(9))
            0: h = 0;
            1: h = int'($urandom_range(127, 65));
            default: h = int'($urandom_range(64, 1));
        endcase
        set_cursor(int'($urandom_range(4200)) - 100, int'($urandom_range(4200)) - 100,
                   w, h, $urandom_range(9) != 0);
    endtask

    // Driver: offers queued items, predicts each transfer as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (on_bus.command == CMD_BLEND)
                    expected_px.push_back(blend_expect(on_bus));
                else
                    cursor_img[on_bus.idx] = on_bus.argb;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && (steady_flow || $urandom_range(99) >= 30)) begin
                    on_bus = pending_items.pop_front();
                    s_command      <= on_bus.command;
                    s_pixel_x      <= on_bus.x;
                    s_pixel_y      <= on_bus.y;
                    s_cursor_index <= on_bus.idx;
                    s_cursor_argb  <= on_bus.argb;
                    s_dst_blue     <= on_bus.dst.blue;
                    s_dst_green    <= on_bus.dst.green;
                    s_dst_red      <= on_bus.dst.red;
                    s_dst_alpha    <= on_bus.dst.alpha;
                    s_valid        <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output transfer and throttles m_ready
    always @(posedge aclk) begin
        blended_px_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected output pixel b=%0d g=%0d r=%0d a=%0d hit=%0d",
                                 m_out_blue, m_out_green, m_out_red, m_out_alpha,
                                 m_cursor_hit);
                end else begin
                    want = expected_px.pop_front();
                    if (m_out_blue !== want.pix.blue || m_out_green !== want.pix.green ||
                        m_out_red !== want.pix.red || m_out_alpha !== want.pix.alpha ||
                        m_cursor_hit !== want.hit) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("pixel mismatch: exp b=%0d g=%0d r=%0d a=%0d hit=%0d, %s",
                                     want.pix.blue, want.pix.green, want.pix.red,
                                     want.pix.alpha, want.hit,
                                     $sformatf("got b=%0d g=%0d r=%0d a=%0d hit=%0d",
                                               m_out_blue, m_out_green, m_out_red,
                                               m_out_alpha, m_cursor_hit));
                    end
                end
            end
            // long hold-off on request, otherwise random back-pressure
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (stalls_served != stall_requests) begin
                stalls_served <= stalls_served + 1;
                hold_left     <= HOLD_CYCLES;
                m_ready       <= 1'b0;
            end else begin
                m_ready <= steady_flow || ($urandom_range(99) >= 30);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: corners of the image, opaque, transparent and partial alpha
        push_load(0, 32'hFF123456);
        push_blend(0, 0, 32'h00000000);
        push_load(4095, 32'h00FFFFFF);
        push_blend(63, 63, 32'hFFFFFFFF);
        push_load(1, 32'h80FF00FF);
        push_blend(1, 0, 32'h00FF8055);
        push_load(64, 32'h01FFFFFF);
        push_blend(0, 1, 32'h00000000);
        push_load(65, 32'hFE000000);
        push_blend(1, 1, 32'hFFFFFFFF);
        push_blend(4095, 4095, 32'hA5A5A5A5);
        push_blend(64, 0, 32'h12345678);
        push_blend(0, 64, 32'h9ABCDEF0);
        push_load(2, 32'hFFFFFFFF);
        push_blend(2, 0, 32'h00000000);
        push_load(4095, 32'h7F00FF00);
        push_blend(63, 63, 32'h00FF00FF);
        push_load(3, 32'hC0ABCDEF);
        push_blend(3, 0, 32'hFFFFFFFF);

        // Cursor far off the frame at the register extremes
        set_cursor(-8192, 8191, 64, 64, 1'b1);
        gen_traffic(30);
        set_cursor(8191, -8192, 64, 64, 1'b1);
        gen_traffic(20);
        // Clipped at the top-left and at the bottom-right
        set_cursor(-5, -3, 17, 9, 1'b1);
        gen_traffic(60);
        set_cursor(4090, 4093, 64, 64, 1'b1);
        gen_traffic(60);
        // Zero width gives an empty rectangle
        set_cursor(100, 100, 0, 1, 1'b1);
        gen_traffic(30);
        // Oversized cursor saturates; receiver holds off while the sender keeps going
        set_cursor(10, 20, 100, 127, 1'b1);
        stall_requests++;
        gen_traffic(60);
        // Overlay disabled
        set_cursor(30, 30, 64, 64, 1'b0);
        gen_traffic(40);
        // Single pixel cursor
        set_cursor(int'($urandom_range(4095)), int'($urandom_range(4095)), 1, 1, 1'b1);
        gen_traffic(40);
        for (k = 0; k < 4; k++) begin
            random_cursor();
            gen_traffic(50);
        end
        // Back-to-back stretch with no idling on either side
        random_cursor();
        steady_flow = 1'b1;
        gen_traffic(100);

        wait_drained();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

>>> cursor_alpha_overlay_top.f
hdl/cao_pkg.sv
hdl/cao_locate.sv
hdl/cao_store.sv
hdl/cao_blend.sv
hdl/cursor_alpha_overlay_top.sv
tb/tb.sv
